// File: src/hbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_pkg
// Types, widths and helpers shared by the bilinear height sampler modules.
// ----------------------------------------------------------------------------
package hbs_pkg;

    // Grid geometry
    localparam int GRID_SIZE  = 64;
    localparam int IDX_W      = $clog2(GRID_SIZE);
    localparam int IDX_MAX    = GRID_SIZE - 2;
    // Store is split into four banks by column and row parity
    localparam int HALF       = (GRID_SIZE + 1) / 2;
    localparam int XH_W       = IDX_W - 1;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int NUM_BANKS  = 4;

    // Arithmetic widths
    localparam int H_W     = 16;              // stored height, Q7.8
    localparam int S_W     = 16;              // scale, Q8.8
    localparam int W_W     = 18;              // fractions and weights
    localparam int P_W     = H_W + W_W;       // h * w
    localparam int R_W     = P_W + 1;         // row blend, Q.16
    localparam int Q_W     = R_W + W_W;       // r * w
    localparam int T_W     = Q_W + 1;         // full blend, Q.24
    localparam int TLO_W   = 26;              // low slice of t, unsigned
    localparam int THI_W   = T_W - TLO_W;     // high slice of t, signed
    localparam int MH_W    = THI_W + S_W;
    localparam int ML_W    = TLO_W + 1 + S_W;
    localparam int SUM_W   = MH_W + TLO_W;
    localparam int FRAC_SH = 24;
    localparam int RES_W   = SUM_W - FRAC_SH;

    localparam int ONE_Q8 = 256;              // 1.0 in Q.8
    localparam logic [S_W-1:0] SCALE_RESET = S_W'(ONE_Q8);

    localparam logic signed [31:0] HEIGHT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] HEIGHT_MIN = 32'sh8000_0000;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Delay from an accepted query to its result strobe being sampled
    localparam int LATENCY = 9;

    typedef struct packed {
        logic                  req_type;
        logic [5:0]            cell_x;
        logic [5:0]            cell_y;
        logic signed [H_W-1:0] cell_height;
        logic signed [15:0]    query_x;
        logic signed [15:0]    query_y;
    } t_req;

    typedef struct packed {
        logic signed [31:0] height;
        logic               saturated;
    } t_result;

    // Neighbors in order h00, h10, h01, h11
    typedef logic [NUM_BANKS-1:0][H_W-1:0] t_quad;

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [XH_W-1:0] yh,
                                                     input logic [XH_W-1:0] xh);
        return BANK_AW'(BANK_AW'(yh) * BANK_AW'(HALF) + BANK_AW'(xh));
    endfunction

endpackage
`default_nettype wire

// File: src/heightmap_bilinear_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// Bilinear height-grid sampler with a Q8.8 output scale.
// ----------------------------------------------------------------------------
// Takes one beat every clock: busy is always low. A load beat writes one grid
// cell and returns nothing; a query beat returns one result, strobed on
// o_valid for a single cycle. Results come out in query order and the
// receiver has to capture them in that cycle, since it cannot stall.
// The rate is one beat per cycle because the grid lives in four
// column/row-parity banks, each with one write and one read port, so a query
// reads its four neighbors in the same cycle while a load writes alongside.
// A load is visible to every query taken after it. The grid is not cleared
// on reset: query only cells already loaded. Write the scale only while no
// query is in flight.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire hbs_pkg::t_req                 i_req,
    input  wire logic                          i_cfg_we,
    input  wire logic [hbs_pkg::S_W-1:0]       i_cfg_wdata,
    output logic                               o_valid,
    output hbs_pkg::t_result                   o_result
);
    import hbs_pkg::*;

    function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [7:0] fl);
        if (fl < 0) begin
            return IDX_W'(0);
        end else if (int'(fl) > IDX_MAX) begin
            return IDX_W'(IDX_MAX);
        end
        return IDX_W'(fl);
    endfunction

    function automatic logic signed [W_W-1:0] frac(input logic signed [15:0] q,
                                                   input logic [IDX_W-1:0]   idx);
        return $signed({{(W_W-16){q[15]}}, q}) - $signed(W_W'({idx, 8'h00}));
    endfunction

    logic                  accept;
    logic                  n_s0_valid, n_s0_we;
    logic [IDX_W-1:0]      n_s0_ix, n_s0_iy;

    logic                  r_s0_valid, r_s0_we;
    logic [1:0]            r_s0_wbank;
    logic [BANK_AW-1:0]    r_s0_waddr;
    logic [H_W-1:0]        r_s0_wdata;
    logic [IDX_W-1:0]      r_s0_ix, r_s0_iy;
    logic signed [W_W-1:0] r_s0_fx, r_s0_fy;

    logic [XH_W-1:0]       xh [2];
    logic [XH_W-1:0]       yh [2];
    t_quad                 rd;
    t_quad                 quad;

    logic                  r_s1_valid, r_s1_px, r_s1_py;
    logic signed [W_W-1:0] r_s1_fx, r_s1_fy;
    logic [S_W-1:0]        r_scale;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign n_s0_valid = accept && (i_req.req_type == REQ_QUERY);
    assign n_s0_we    = accept && (i_req.req_type == REQ_LOAD)
                        && (int'(i_req.cell_x) < GRID_SIZE)
                        && (int'(i_req.cell_y) < GRID_SIZE);
    assign n_s0_ix    = clamp_idx(i_req.query_x[15:8]);
    assign n_s0_iy    = clamp_idx(i_req.query_y[15:8]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s0_we    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_scale    <= SCALE_RESET;
        end else begin
            r_s0_valid <= n_s0_valid;
            r_s0_we    <= n_s0_we;
            r_s1_valid <= r_s0_valid;
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_wbank <= {i_req.cell_y[0], i_req.cell_x[0]};
        r_s0_waddr <= bank_addr(XH_W'(i_req.cell_y >> 1), XH_W'(i_req.cell_x >> 1));
        r_s0_wdata <= i_req.cell_height;
        r_s0_ix    <= n_s0_ix;
        r_s0_iy    <= n_s0_iy;
        r_s0_fx    <= frac(i_req.query_x, n_s0_ix);
        r_s0_fy    <= frac(i_req.query_y, n_s0_iy);

        r_s1_px    <= r_s0_ix[0];
        r_s1_py    <= r_s0_iy[0];
        r_s1_fx    <= r_s0_fx;
        r_s1_fy    <= r_s0_fy;
    end

    // Even bank holds the cell at index+1 when the index is odd
    assign xh[0] = XH_W'(r_s0_ix >> 1) + XH_W'(r_s0_ix[0]);
    assign xh[1] = XH_W'(r_s0_ix >> 1);
    assign yh[0] = XH_W'(r_s0_iy >> 1) + XH_W'(r_s0_iy[0]);
    assign yh[1] = XH_W'(r_s0_iy >> 1);

    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        localparam int PX = b % 2;
        localparam int PY = b / 2;

        hbs_ram #(
            .DEPTH (BANK_DEPTH),
            .WIDTH (H_W)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_s0_we && (r_s0_wbank == 2'(b))),
            .i_waddr (r_s0_waddr),
            .i_wdata (r_s0_wdata),
            .i_raddr (bank_addr(yh[PY], xh[PX])),
            .o_rdata (rd[b])
        );
    end

    // Map banks back to h00, h10, h01, h11
    assign quad[0] = rd[{ r_s1_py,  r_s1_px}];
    assign quad[1] = rd[{ r_s1_py, !r_s1_px}];
    assign quad[2] = rd[{!r_s1_py,  r_s1_px}];
    assign quad[3] = rd[{!r_s1_py, !r_s1_px}];

    hbs_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_h      (quad),
        .i_fx     (r_s1_fx),
        .i_fy     (r_s1_fy),
        .i_scale  ($signed(r_scale)),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Every accepted query yields exactly one result after the fixed latency
    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.req_type == REQ_QUERY)) |-> ##LATENCY o_valid)
        else $error("query beat produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_req.req_type == REQ_QUERY), LATENCY))
        else $error("result without a matching query beat");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
            (o_result.height == HEIGHT_MAX || o_result.height == HEIGHT_MIN))
        else $error("saturated flag with unclipped height");

endmodule
`default_nettype wire

// File: src/hbs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: src/hbs_blend.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_blend
// Pipelined bilinear blend, scale, floor shift and 32-bit saturation.
// ----------------------------------------------------------------------------
module hbs_blend (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire hbs_pkg::t_quad                i_h,
    input  wire logic signed [hbs_pkg::W_W-1:0] i_fx,
    input  wire logic signed [hbs_pkg::W_W-1:0] i_fy,
    input  wire logic signed [hbs_pkg::S_W-1:0] i_scale,
    output logic                               o_valid,
    output hbs_pkg::t_result                   o_result
);
    import hbs_pkg::*;

    logic signed [W_W-1:0]   wx0, wy0;
    logic signed [SUM_W-1:0] sum;
    logic                    pos_ov, neg_ov;

    logic r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;

    logic signed [P_W-1:0]   r_p00, r_p10, r_p01, r_p11;
    logic signed [W_W-1:0]   r_wy0_2, r_wy1_2, r_wy0_3, r_wy1_3;
    logic signed [R_W-1:0]   r_r0, r_r1;
    logic signed [Q_W-1:0]   r_q0, r_q1;
    logic signed [T_W-1:0]   r_t;
    logic signed [MH_W-1:0]  r_mh;
    logic signed [ML_W-1:0]  r_ml;
    logic signed [RES_W-1:0] r_res;
    t_result                 r_out;

    assign wx0 = $signed(W_W'(ONE_Q8)) - i_fx;
    assign wy0 = $signed(W_W'(ONE_Q8)) - i_fy;

    // t * scale as (hi << TLO_W + lo) * scale, then floor by arithmetic select
    assign sum = (SUM_W'(r_mh) <<< TLO_W) + SUM_W'(r_ml);

    assign pos_ov = !r_res[RES_W-1] && (|r_res[RES_W-2:31]);
    assign neg_ov =  r_res[RES_W-1] && !(&r_res[RES_W-2:31]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        // weight the four corners along x
        r_p00   <= $signed(i_h[0]) * wx0;
        r_p10   <= $signed(i_h[1]) * i_fx;
        r_p01   <= $signed(i_h[2]) * wx0;
        r_p11   <= $signed(i_h[3]) * i_fx;
        r_wy0_2 <= wy0;
        r_wy1_2 <= i_fy;
        // row sums
        r_r0    <= R_W'(r_p00) + R_W'(r_p10);
        r_r1    <= R_W'(r_p01) + R_W'(r_p11);
        r_wy0_3 <= r_wy0_2;
        r_wy1_3 <= r_wy1_2;
        // weight along y
        r_q0    <= r_r0 * r_wy0_3;
        r_q1    <= r_r1 * r_wy1_3;
        r_t     <= T_W'(r_q0) + T_W'(r_q1);
        // scale
        r_mh    <= $signed(r_t[T_W-1:TLO_W]) * i_scale;
        r_ml    <= $signed({1'b0, r_t[TLO_W-1:0]}) * i_scale;
        r_res   <= sum[SUM_W-1:FRAC_SH];
        // clip to 32 bits
        if (pos_ov) begin
            r_out.height <= HEIGHT_MAX;
        end else if (neg_ov) begin
            r_out.height <= HEIGHT_MIN;
        end else begin
            r_out.height <= r_res[31:0];
        end
        r_out.saturated <= pos_ov || neg_ov;
    end

    assign o_valid  = r_v8;
    assign o_result = r_out;

endmodule
`default_nettype wire
